// ===== rtl/ngp_pkg.sv =====
// Shared types and constants of the NMEA GGA/RMC sentence parser.
package ngp_pkg;

	// Depth of the beat queue between the front and the back; a power of two.
	localparam int QDEPTH = 4;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_UA     = 8'h41;
	localparam logic [7:0] CH_UF     = 8'h46;
	localparam logic [7:0] CH_UC     = 8'h43;
	localparam logic [7:0] CH_UG     = 8'h47;
	localparam logic [7:0] CH_UM     = 8'h4D;
	localparam logic [7:0] CH_UR     = 8'h52;
	localparam logic [7:0] CH_US     = 8'h53;
	localparam logic [7:0] CH_UW     = 8'h57;

	// Integer part of a field number saturates here.
	localparam logic [19:0] NUM_SAT = 20'd999999;

	typedef enum logic [2:0] {
		C_DOLLAR,
		C_EOL,
		C_COMMA,
		C_DIGIT,
		C_DOT,
		C_OTHER
	} cls_t;

	typedef enum logic [2:0] {
		EV_NONE,
		EV_GGA,
		EV_RMC,
		EV_BAD,
		EV_OTHER
	} ev_t;

	// One queued beat, already classified by the front.
	typedef struct packed {
		logic       restart;
		logic [7:0] ch;
		cls_t       cls;
		logic [3:0] dig;
	} beat_t;

	// Result of one beat as handed to the output port.
	typedef struct packed {
		logic               done;
		ev_t                event_res;
		logic [6:0]         hour;
		logic [6:0]         minute;
		logic [6:0]         second;
		logic signed [24:0] latitude;
		logic signed [25:0] longitude;
		logic [3:0]         fix_quality;
		logic [6:0]         satellites;
		logic [6:0]         day;
		logic [6:0]         month;
		logic [6:0]         year;
	} res_t;

endpackage

// ===== rtl/ngp_front.sv =====
// Front of the parser: classifies incoming bytes and queues them for the back.
module ngp_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          in_cmd,
	input  logic [7:0]    in_byte,
	output logic          head_valid,
	output ngp_pkg::beat_t head,
	input  logic          pop
);

	localparam int AW = $clog2(ngp_pkg::QDEPTH);

	ngp_pkg::beat_t mem_q [ngp_pkg::QDEPTH];
	logic [AW-1:0]  wr_q;
	logic [AW-1:0]  rd_q;
	logic [AW:0]    cnt_q;
	ngp_pkg::beat_t nb;
	logic           push;

	always_comb begin
		nb.restart = in_cmd;
		nb.ch      = in_byte;
		nb.dig     = 4'(in_byte - ngp_pkg::CH_ZERO);
		case (in_byte) inside
			ngp_pkg::CH_DOLLAR:                 nb.cls = ngp_pkg::C_DOLLAR;
			ngp_pkg::CH_CR, ngp_pkg::CH_LF:     nb.cls = ngp_pkg::C_EOL;
			ngp_pkg::CH_COMMA:                  nb.cls = ngp_pkg::C_COMMA;
			[ngp_pkg::CH_ZERO:ngp_pkg::CH_NINE]: nb.cls = ngp_pkg::C_DIGIT;
			ngp_pkg::CH_DOT:                    nb.cls = ngp_pkg::C_DOT;
			default:                            nb.cls = ngp_pkg::C_OTHER;
		endcase
	end

	assign in_ready   = cnt_q != (AW+1)'(ngp_pkg::QDEPTH);
	assign head_valid = cnt_q != '0;
	assign push       = in_valid & in_ready;
	assign head       = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= nb;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/ngp_deg_conv.sv =====
// Six-stage pipeline that turns a ddmm.mmm field into degrees times 100000.
module ngp_deg_conv (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [19:0] int_part,
	input  logic [9:0]  frac_part,
	input  logic [1:0]  frac_digits,
	input  logic        is_lon,
	output logic        busy,
	output logic        res_valid,
	output logic [24:0] res
);

	localparam logic [24:0] LAT_RAW_MAX = 25'd9059999;
	localparam logic [24:0] LON_RAW_MAX = 25'd18059999;
	// floor(2^37 / 100000), the quotient estimate is low by at most one.
	localparam logic [20:0] RECIP_1E5   = 21'd1374389;
	// ceil(2^21 / 3), exact for the values seen here.
	localparam logic [19:0] RECIP_3     = 20'd699051;
	localparam logic [16:0] TEN_5       = 17'd100000;

	logic [5:0]  v_q;
	logic [24:0] raw_s1, raw_s2;
	logic [7:0]  q_s2, q_s3, q_s4;
	logic [17:0] r_s3;
	logic [16:0] r_s4;
	// Minutes part times 10/6 reaches 166665, which needs 18 bits.
	logic [17:0] y_s5;
	logic [24:0] qh_s5, res_s6;

	logic [6:0]  scale;
	logic [29:0] raw_full;
	logic [24:0] limit;
	logic [45:0] qprod;
	logic [24:0] qmul;
	logic [18:0] r5;
	logic [38:0] yprod;

	always_comb begin
		case (frac_digits)
			2'd1:    scale = 7'd100;
			2'd2:    scale = 7'd10;
			2'd3:    scale = 7'd1;
			default: scale = 7'd0;
		endcase
		raw_full = 30'(int_part) * 30'd1000 + 30'(frac_part) * 30'(scale);
		limit    = is_lon ? LON_RAW_MAX : LAT_RAW_MAX;
		qprod    = 46'(raw_s1) * 46'(RECIP_1E5);
		qmul     = 25'(q_s2) * 25'(TEN_5);
		r5       = 19'(r_s4) + {r_s4, 2'b00};
		yprod    = 39'(r5) * 39'(RECIP_3);
	end

	always_ff @(posedge clk) begin
		raw_s1 <= (raw_full > 30'(limit)) ? limit : raw_full[24:0];
		raw_s2 <= raw_s1;
		q_s2   <= qprod[44:37];
		r_s3   <= 18'(raw_s2 - qmul);
		q_s3   <= q_s2;
		if (r_s3 >= 18'(TEN_5)) begin
			q_s4 <= q_s3 + 8'd1;
			r_s4 <= 17'(r_s3 - 18'(TEN_5));
		end else begin
			q_s4 <= q_s3;
			r_s4 <= r_s3[16:0];
		end
		y_s5   <= yprod[38:21];
		qh_s5  <= 25'(q_s4) * 25'(TEN_5);
		res_s6 <= qh_s5 + 25'(y_s5);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			v_q <= {v_q[4:0], start};
		end
	end

	assign busy      = |v_q;
	assign res_valid = v_q[5];
	assign res       = res_s6;

endmodule

// ===== rtl/ngp_back.sv =====
// Back of the parser: sentence state, field accumulation, checksum and commit.
module ngp_back #(
	parameter int MAX_LEN = 128
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           head_valid,
	input  ngp_pkg::beat_t head,
	output logic           pop,
	output logic           m_valid,
	input  logic           m_ready,
	output ngp_pkg::res_t  res
);

	localparam int PW = $clog2(MAX_LEN + 1);

	typedef enum logic [1:0] {K_PEND, K_GGA, K_RMC, K_OTHER} kind_t;
	typedef enum logic [1:0] {M_INT, M_FRAC, M_STOP} mode_t;

	function automatic logic [6:0] bcd2(input logic [7:0] b);
		logic [6:0] hi;
		hi = {3'b000, b[7:4]};
		return (hi << 3) + (hi << 1) + {3'b000, b[3:0]};
	endfunction

	function automatic logic is_hex(input logic [7:0] c);
		return (c >= ngp_pkg::CH_ZERO && c <= ngp_pkg::CH_NINE) ||
		       (c >= ngp_pkg::CH_UA && c <= ngp_pkg::CH_UF);
	endfunction

	function automatic logic [3:0] hex_val(input logic [7:0] c);
		return (c <= ngp_pkg::CH_NINE) ? 4'(c - ngp_pkg::CH_ZERO)
		                               : 4'(c - ngp_pkg::CH_UA + 8'd10);
	endfunction

	// Sentence state.
	logic          in_sent_q, nx_in_sent;
	logic [PW-1:0] pos_q, nx_pos;
	logic [4:0]    field_q, nx_field;
	logic [7:0]    xr_q, nx_xr;
	logic [7:0]    rc0_q, rc1_q, rc2_q, nx_rc0, nx_rc1, nx_rc2;
	kind_t         kind_q, nx_kind;
	logic [6:0]    th_q, tm_q, ts_q, nx_th, nx_tm, nx_ts;
	logic [23:0]   lat_q, nx_lat;
	logic [24:0]   lon_q, nx_lon;
	logic [1:0]    hemi_q, nx_hemi;
	logic [3:0]    fixa_q, nx_fixa;
	logic [6:0]    sata_q, nx_sata;
	logic [6:0]    dd_q, dm_q, dy_q, nx_dd, nx_dm, nx_dy;
	logic          dnz_q, nx_dnz;
	// Number reader of the current field.
	logic [19:0]   ival_q, nx_ival;
	logic [23:0]   bcd_q, nx_bcd;
	logic [9:0]    frac_q, nx_frac;
	logic [1:0]    fd_q, nx_fd;
	mode_t         mode_q, nx_mode;
	logic          gga_q, rmc_q, nx_gga, nx_rmc;
	// Committed values.
	logic [6:0]         ch_q, cm_q, cs_q, nx_ch, nx_cm, nx_cs;
	logic signed [24:0] clat_q, nx_clat;
	logic signed [25:0] clon_q, nx_clon;
	logic [3:0]         cfix_q, nx_cfix;
	logic [6:0]         csat_q, nx_csat;
	logic [6:0]         cday_q, cmon_q, cyr_q, nx_cday, nx_cmon, nx_cyr;
	ngp_pkg::ev_t       ev_q, nx_ev;
	logic               out_valid_q;

	// Field-end view of the accumulators.
	logic [6:0]  fe_th, fe_tm, fe_ts, fe_dd, fe_dm, fe_dy, fe_sata;
	logic [23:0] fe_lat;
	logic [24:0] fe_lon;
	logic [3:0]  fe_fixa;
	logic        fe_dnz;

	logic        done_now, active, need_conv, conv_start;
	logic        conv_busy, conv_valid, conv_done_q;
	logic [24:0] conv_res, conv_res_q;
	logic [23:0] int10;
	logic [7:0]  sum;
	logic        ck_ok, do_clr;
	logic [PW-1:0] pos_inc;

	ngp_deg_conv u_conv (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (conv_start),
		.int_part    (ival_q),
		.frac_part   (frac_q),
		.frac_digits (fd_q),
		.is_lon      (field_q == 5'd4),
		.busy        (conv_busy),
		.res_valid   (conv_valid),
		.res         (conv_res)
	);

	assign done_now  = gga_q & rmc_q;
	assign active    = !head.restart && !done_now;
	assign need_conv = head_valid && active && in_sent_q &&
	                   (head.cls == ngp_pkg::C_COMMA || head.cls == ngp_pkg::C_EOL) &&
	                   (field_q == 5'd2 || field_q == 5'd4);
	assign conv_start = need_conv && !conv_done_q && !conv_busy;
	assign pop = head_valid && (!out_valid_q || m_ready) && (!need_conv || conv_done_q);

	always_comb begin
		fe_th = th_q; fe_tm = tm_q; fe_ts = ts_q;
		fe_lat = lat_q; fe_lon = lon_q;
		fe_fixa = fixa_q; fe_sata = sata_q;
		fe_dd = dd_q; fe_dm = dm_q; fe_dy = dy_q; fe_dnz = dnz_q;
		case (field_q)
			5'd1: begin
				fe_th = bcd2(bcd_q[23:16]);
				fe_tm = bcd2(bcd_q[15:8]);
				fe_ts = bcd2(bcd_q[7:0]);
			end
			5'd2: fe_lat = conv_res_q[23:0];
			5'd4: fe_lon = conv_res_q;
			5'd6: fe_fixa = (ival_q > 20'd15) ? 4'd15 : ival_q[3:0];
			5'd7: fe_sata = (ival_q > 20'd99) ? 7'd99 : ival_q[6:0];
			5'd9: begin
				fe_dd  = bcd2(bcd_q[23:16]);
				fe_dm  = bcd2(bcd_q[15:8]);
				fe_dy  = bcd2(bcd_q[7:0]);
				fe_dnz = ival_q != '0;
			end
			default: ;
		endcase
	end

	always_comb begin
		nx_in_sent = in_sent_q; nx_pos = pos_q; nx_field = field_q; nx_xr = xr_q;
		nx_rc0 = rc0_q; nx_rc1 = rc1_q; nx_rc2 = rc2_q; nx_kind = kind_q;
		nx_th = th_q; nx_tm = tm_q; nx_ts = ts_q; nx_lat = lat_q; nx_lon = lon_q;
		nx_hemi = hemi_q; nx_fixa = fixa_q; nx_sata = sata_q;
		nx_dd = dd_q; nx_dm = dm_q; nx_dy = dy_q; nx_dnz = dnz_q;
		nx_ival = ival_q; nx_bcd = bcd_q; nx_frac = frac_q; nx_fd = fd_q; nx_mode = mode_q;
		nx_gga = gga_q; nx_rmc = rmc_q;
		nx_ch = ch_q; nx_cm = cm_q; nx_cs = cs_q; nx_clat = clat_q; nx_clon = clon_q;
		nx_cfix = cfix_q; nx_csat = csat_q; nx_cday = cday_q; nx_cmon = cmon_q;
		nx_cyr = cyr_q;
		nx_ev = ngp_pkg::EV_NONE;
		do_clr = 1'b0;
		pos_inc = pos_q + 1'b1;
		int10 = ({4'd0, ival_q} << 3) + ({4'd0, ival_q} << 1) + 24'(head.dig);
		sum = xr_q ^ rc0_q ^ rc1_q ^ rc2_q;
		ck_ok = (pos_q >= PW'(4)) && (rc0_q == ngp_pkg::CH_STAR) &&
		        is_hex(rc1_q) && is_hex(rc2_q) && (sum == {hex_val(rc1_q), hex_val(rc2_q)});

		if (head.restart) begin
			nx_gga = 1'b0;
			nx_rmc = 1'b0;
			nx_in_sent = 1'b0;
			do_clr = 1'b1;
		end else if (!done_now) begin
			case (head.cls)
				ngp_pkg::C_DOLLAR: begin
					do_clr = 1'b1;
					nx_in_sent = 1'b1;
				end
				ngp_pkg::C_EOL: begin
					if (in_sent_q) begin
						nx_th = fe_th; nx_tm = fe_tm; nx_ts = fe_ts;
						nx_lat = fe_lat; nx_lon = fe_lon;
						nx_fixa = fe_fixa; nx_sata = fe_sata;
						nx_dd = fe_dd; nx_dm = fe_dm; nx_dy = fe_dy; nx_dnz = fe_dnz;
						if (!ck_ok) begin
							nx_ev = ngp_pkg::EV_BAD;
						end else if (kind_q == K_GGA) begin
							nx_ch = fe_th; nx_cm = fe_tm; nx_cs = fe_ts;
							nx_clat = hemi_q[0] ? -$signed({1'b0, fe_lat}) : $signed({1'b0, fe_lat});
							nx_clon = hemi_q[1] ? -$signed({1'b0, fe_lon}) : $signed({1'b0, fe_lon});
							nx_cfix = fe_fixa;
							nx_csat = fe_sata;
							if (fe_fixa != '0) begin
								nx_gga = 1'b1;
							end
							nx_ev = ngp_pkg::EV_GGA;
						end else if (kind_q == K_RMC) begin
							if (fe_dnz) begin
								nx_cday = fe_dd; nx_cmon = fe_dm; nx_cyr = fe_dy;
								nx_rmc = 1'b1;
								nx_ev = ngp_pkg::EV_RMC;
							end
						end else begin
							nx_ev = ngp_pkg::EV_OTHER;
						end
					end
					nx_in_sent = 1'b0;
				end
				default: begin
					if (in_sent_q) begin
						if (head.cls == ngp_pkg::C_COMMA) begin
							nx_th = fe_th; nx_tm = fe_tm; nx_ts = fe_ts;
							nx_lat = fe_lat; nx_lon = fe_lon;
							nx_fixa = fe_fixa; nx_sata = fe_sata;
							nx_dd = fe_dd; nx_dm = fe_dm; nx_dy = fe_dy; nx_dnz = fe_dnz;
							if (field_q == '0) begin
								if (kind_q == K_PEND && pos_q == PW'(6) &&
								    rc0_q == ngp_pkg::CH_UG && rc1_q == ngp_pkg::CH_UG &&
								    rc2_q == ngp_pkg::CH_UA) begin
									nx_kind = K_GGA;
								end else if (kind_q == K_PEND && pos_q == PW'(6) &&
								             rc0_q == ngp_pkg::CH_UR && rc1_q == ngp_pkg::CH_UM &&
								             rc2_q == ngp_pkg::CH_UC) begin
									nx_kind = K_RMC;
								end else begin
									nx_kind = K_OTHER;
								end
							end
							if (field_q != 5'd31) begin
								nx_field = field_q + 5'd1;
							end
							nx_ival = '0; nx_bcd = '0; nx_frac = '0; nx_fd = '0;
							nx_mode = M_INT;
						end else begin
							if (pos_q == PW'(1) && head.ch != ngp_pkg::CH_UG) begin
								nx_kind = K_OTHER;
							end
							if (rc2_q == ngp_pkg::CH_COMMA) begin
								if (field_q == 5'd3 && head.ch == ngp_pkg::CH_US) begin
									nx_hemi[0] = 1'b1;
								end
								if (field_q == 5'd5 && head.ch == ngp_pkg::CH_UW) begin
									nx_hemi[1] = 1'b1;
								end
							end
							if (mode_q != M_STOP) begin
								if (head.cls == ngp_pkg::C_DIGIT) begin
									if (mode_q == M_INT) begin
										if (int10 > 24'(ngp_pkg::NUM_SAT)) begin
											nx_ival = ngp_pkg::NUM_SAT;
											nx_bcd  = 24'h999999;
										end else begin
											nx_ival = int10[19:0];
											nx_bcd  = {bcd_q[19:0], head.dig};
										end
									end else if (fd_q != 2'd3) begin
										nx_frac = (frac_q << 3) + (frac_q << 1) + 10'(head.dig);
										nx_fd   = fd_q + 2'd1;
									end
								end else if (head.cls == ngp_pkg::C_DOT && mode_q == M_INT) begin
									nx_mode = M_FRAC;
								end else begin
									nx_mode = M_STOP;
								end
							end
						end
						nx_xr = xr_q ^ head.ch;
						nx_rc0 = rc1_q; nx_rc1 = rc2_q; nx_rc2 = head.ch;
						nx_pos = pos_inc;
						if (pos_inc >= PW'(MAX_LEN)) begin
							nx_in_sent = 1'b0;
						end
					end
				end
			endcase
		end

		if (do_clr) begin
			nx_pos = (head.cls == ngp_pkg::C_DOLLAR && !head.restart) ? PW'(1) : '0;
			nx_field = '0; nx_xr = '0; nx_rc0 = '0; nx_rc1 = '0; nx_rc2 = '0;
			nx_kind = K_PEND;
			nx_th = '0; nx_tm = '0; nx_ts = '0; nx_lat = '0; nx_lon = '0;
			nx_dd = '0; nx_dm = '0; nx_dy = '0; nx_dnz = 1'b0;
			nx_hemi = '0; nx_fixa = '0; nx_sata = '0;
			nx_ival = '0; nx_bcd = '0; nx_frac = '0; nx_fd = '0; nx_mode = M_INT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_sent_q <= 1'b0; pos_q <= '0; field_q <= '0; xr_q <= '0;
			rc0_q <= '0; rc1_q <= '0; rc2_q <= '0; kind_q <= K_PEND;
			th_q <= '0; tm_q <= '0; ts_q <= '0; lat_q <= '0; lon_q <= '0;
			hemi_q <= '0; fixa_q <= '0; sata_q <= '0;
			dd_q <= '0; dm_q <= '0; dy_q <= '0; dnz_q <= 1'b0;
			ival_q <= '0; bcd_q <= '0; frac_q <= '0; fd_q <= '0; mode_q <= M_INT;
			gga_q <= 1'b0; rmc_q <= 1'b0;
			ch_q <= '0; cm_q <= '0; cs_q <= '0; clat_q <= '0; clon_q <= '0;
			cfix_q <= '0; csat_q <= '0; cday_q <= '0; cmon_q <= '0; cyr_q <= '0;
			ev_q <= ngp_pkg::EV_NONE;
			out_valid_q <= 1'b0;
			conv_done_q <= 1'b0;
			conv_res_q  <= '0;
		end else begin
			if (conv_valid) begin
				conv_done_q <= 1'b1;
				conv_res_q  <= conv_res;
			end
			if (pop) begin
				conv_done_q <= 1'b0;
				in_sent_q <= nx_in_sent; pos_q <= nx_pos; field_q <= nx_field; xr_q <= nx_xr;
				rc0_q <= nx_rc0; rc1_q <= nx_rc1; rc2_q <= nx_rc2; kind_q <= nx_kind;
				th_q <= nx_th; tm_q <= nx_tm; ts_q <= nx_ts; lat_q <= nx_lat; lon_q <= nx_lon;
				hemi_q <= nx_hemi; fixa_q <= nx_fixa; sata_q <= nx_sata;
				dd_q <= nx_dd; dm_q <= nx_dm; dy_q <= nx_dy; dnz_q <= nx_dnz;
				ival_q <= nx_ival; bcd_q <= nx_bcd; frac_q <= nx_frac; fd_q <= nx_fd;
				mode_q <= nx_mode;
				gga_q <= nx_gga; rmc_q <= nx_rmc;
				ch_q <= nx_ch; cm_q <= nx_cm; cs_q <= nx_cs; clat_q <= nx_clat;
				clon_q <= nx_clon; cfix_q <= nx_cfix; csat_q <= nx_csat;
				cday_q <= nx_cday; cmon_q <= nx_cmon; cyr_q <= nx_cyr;
				ev_q <= nx_ev;
				out_valid_q <= 1'b1;
			end else if (m_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_valid = out_valid_q;

	always_comb begin
		res.done        = gga_q & rmc_q;
		res.event_res   = ev_q;
		res.hour        = ch_q;
		res.minute      = cm_q;
		res.second      = cs_q;
		res.latitude    = clat_q;
		res.longitude   = clon_q;
		res.fix_quality = cfix_q;
		res.satellites  = csat_q;
		res.day         = cday_q;
		res.month       = cmon_q;
		res.year        = cyr_q;
	end

	a_conv_once: assert property (@(posedge clk) disable iff (!arst_n)
		conv_start |-> !conv_done_q)
		else $error("coordinate conversion started twice for one beat");

	a_pop_guard: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (!need_conv || conv_done_q))
		else $error("field end consumed before its conversion finished");

	a_restart_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && head.restart) |=> (!gga_q && !rmc_q))
		else $error("restart did not clear the received flags");

	a_seen_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!pop |=> ($stable(gga_q) && $stable(rmc_q)))
		else $error("received flags changed without a beat");

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		in_sent_q |-> (pos_q < PW'(MAX_LEN)))
		else $error("open sentence beyond the buffer length");

endmodule

// ===== rtl/nmea_gga_rmc_parser.sv =====
// Top level of the NMEA GGA/RMC sentence parser.
//
// The block takes one serial byte per input beat and returns exactly one result
// beat for each input beat. A sentence runs from '$' to CR or LF and counts only
// when it ends in '*' and two uppercase hex digits that match the XOR of the
// bytes after '$'. A good $G?GGA commits time, signed coordinates (degrees times
// 100000, negative for south and west), fix quality and satellites; a good $G?RMC
// with a nonzero date commits day, month and year. Once a fixed GGA and a dated
// RMC have both been seen, done is set and bytes are ignored until a restart
// beat (tuser high). A sentence of MAX_LEN characters or more is dropped.
// Beats pass one per clock while the result port is ready. The exception is the
// byte that closes the second or the fourth field (a comma or the line end): it
// waits while the six-stage coordinate conversion pipeline runs, so any sentence
// that gets past its fourth field waits on two conversions, whatever its type.
// A four-beat queue between the byte classifier and the sentence engine takes
// up to three more beats during such a wait before the input stalls, and an
// output register lets the engine run ahead of a stalled result port by one
// beat. There is no clearing pass after reset.
module nmea_gga_rmc_parser #(
	parameter int MAX_LEN = 128
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // [7:0] rx_byte
	input  logic [0:0]   s_tuser,   // [0] cmd: 0 byte, 1 restart
	output logic         m_tvalid,
	input  logic         m_tready,
	// [0] done_res, [3:1] event_res, [10:4] hour, [17:11] minute,
	// [24:18] second, [49:25] latitude, [75:50] longitude,
	// [79:76] fix_quality, [86:80] satellites, [93:87] day,
	// [100:94] month, [107:101] year, [111:108] zero
	output logic [111:0] m_tdata
);

	logic           head_valid;
	logic           pop;
	ngp_pkg::beat_t head;
	ngp_pkg::res_t  res;

	ngp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_cmd     (s_tuser[0]),
		.in_byte    (s_tdata),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	ngp_back #(
		.MAX_LEN (MAX_LEN)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.m_valid    (m_tvalid),
		.m_ready    (m_tready),
		.res        (res)
	);

	// Pack the result fields, first field in the lowest bits.
	assign m_tdata = {4'b0000, res.year, res.month, res.day, res.satellites,
	                  res.fix_quality, res.longitude, res.latitude, res.second,
	                  res.minute, res.hour, res.event_res, res.done};

endmodule
